### rtl/krs_pkg.sv
// Package for the k-resource interval scheduler: sizes, controller states and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none
package krs_pkg;

    localparam int MAX_INTERVALS = 1024;
    localparam int MAX_RESOURCES = 16;
    localparam int AW            = $clog2(MAX_INTERVALS);
    localparam int CW            = 11;
    localparam int LW            = $clog2(MAX_RESOURCES);
    localparam int KW            = 5;
    localparam int TW            = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_CHK,
        S_KEY_RD,
        S_KEY_LD,
        S_PREV_RD,
        S_CMP,
        S_PLACE,
        S_GR_INIT,
        S_GR_CHK,
        S_GR_RD,
        S_GR_FREE,
        S_GR_DEC,
        S_GR_SCAN,
        S_GR_REPL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic key_rd;
        logic key_ld;
        logic prev_rd;
        logic shift;
        logic place;
        logic gr_init;
        logic gr_rd;
        logic gr_free;
        logic insert;
        logic scan_init;
        logic scan_step;
        logic replace;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic i_done;
        logic j_zero;
        logic prev_gt;
        logic lt_k;
        logic scan_last;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

### rtl/krs_if.sv
// Channel interfaces: interval input and result output, valid/ready handshake.
// Depends on krs_pkg.
`default_nettype none
interface krs_in_if import krs_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [TW-1:0] start_time;
    logic [TW-1:0] end_time;
    logic          last;
    modport source (output valid, start_time, end_time, last, input ready);
    modport sink   (input valid, start_time, end_time, last, output ready);
endinterface

interface krs_out_if import krs_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [CW-1:0] scheduled_count;
    logic          overflow;
    modport source (output valid, scheduled_count, overflow, input ready);
    modport sink   (input valid, scheduled_count, overflow, output ready);
endinterface
`default_nettype wire

### rtl/krs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module krs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/krs_ctrl.sv
// Controller: sequences load, insertion sort and the greedy pass.
// Depends on krs_pkg.
`default_nettype none
module krs_ctrl import krs_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_last,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.sort_init = 1'b1;
                        n_state         = S_SORT_CHK;
                    end
                end
            end
            S_SORT_CHK: n_state = i_status.i_done ? S_GR_INIT : S_KEY_RD;
            S_KEY_RD: begin
                o_cmd.key_rd = 1'b1;
                n_state      = S_KEY_LD;
            end
            S_KEY_LD: begin
                o_cmd.key_ld = 1'b1;
                n_state      = S_PREV_RD;
            end
            S_PREV_RD: begin
                if (i_status.j_zero) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.prev_rd = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                if (i_status.prev_gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = S_PREV_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_SORT_CHK;
            end
            S_GR_INIT: begin
                o_cmd.gr_init = 1'b1;
                n_state       = S_GR_CHK;
            end
            S_GR_CHK: n_state = i_status.i_done ? S_DONE : S_GR_RD;
            S_GR_RD: begin
                o_cmd.gr_rd = 1'b1;
                n_state     = S_GR_FREE;
            end
            S_GR_FREE: begin
                o_cmd.gr_free = 1'b1;
                n_state       = S_GR_DEC;
            end
            S_GR_DEC: begin
                if (i_status.lt_k) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_GR_CHK;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_GR_SCAN;
                end
            end
            S_GR_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_GR_REPL;
                end
            end
            S_GR_REPL: begin
                o_cmd.replace = 1'b1;
                n_state       = S_GR_CHK;
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### rtl/krs_dp.sv
// Datapath: interval store, sort pointers, active end table and result register.
// Depends on krs_pkg and krs_ram.
`default_nettype none
module krs_dp import krs_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic [KW-1:0] i_resource_count,
    input  wire logic [TW-1:0] i_start_time,
    input  wire logic [TW-1:0] i_end_time,
    input  wire logic          i_out_ready,
    output t_status            o_status,
    output logic               o_out_valid,
    output logic [CW-1:0]      o_scheduled_count,
    output logic               o_overflow
);
    logic [CW-1:0]            r_fill;
    logic                     r_ovf;
    logic [CW-1:0]            r_i;
    logic [AW-1:0]            r_j;
    logic [2*TW-1:0]          r_key;
    logic [TW-1:0]            r_e;
    logic [TW-1:0]            r_end [MAX_RESOURCES];
    logic [MAX_RESOURCES-1:0] r_vld;
    logic [CW-1:0]            r_total;
    logic [LW-1:0]            r_lane;
    logic [LW-1:0]            r_mi;
    logic [TW-1:0]            r_max;
    logic                     r_have;
    logic                     r_out_valid;
    logic [CW-1:0]            r_out_count;
    logic                     r_out_ovf;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [2*TW-1:0]          ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [2*TW-1:0]          ram_rdata;
    logic [KW-1:0]            k_eff;
    logic [KW-1:0]            cnt;
    logic [LW-1:0]            free_lane;
    logic                     store_full;
    logic                     take;

    krs_ram #(.WIDTH(2 * TW), .DEPTH(MAX_INTERVALS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign store_full = (r_fill == CW'(MAX_INTERVALS));

    always_comb begin
        ram_we    = (i_cmd.load && !store_full) || i_cmd.shift || i_cmd.place;
        ram_waddr = i_cmd.load ? r_fill[AW-1:0] : r_j;
        ram_wdata = i_cmd.load  ? {i_start_time, i_end_time} :
                    i_cmd.shift ? ram_rdata : r_key;
        ram_raddr = (i_cmd.key_rd || i_cmd.gr_rd) ? r_i[AW-1:0] : (r_j - AW'(1));
    end

    always_comb begin
        if (i_resource_count == '0) begin
            k_eff = KW'(1);
        end else if (i_resource_count > KW'(MAX_RESOURCES)) begin
            k_eff = KW'(MAX_RESOURCES);
        end else begin
            k_eff = i_resource_count;
        end
        cnt       = '0;
        free_lane = '0;
        for (int l = MAX_RESOURCES - 1; l >= 0; l--) begin
            cnt = cnt + KW'(r_vld[l]);
            if (!r_vld[l]) begin
                free_lane = LW'(l);
            end
        end
        take = r_vld[r_lane] && (!r_have || r_end[r_lane] > r_max);
    end

    assign o_status.i_done    = (r_i >= r_fill);
    assign o_status.j_zero    = (r_j == '0);
    assign o_status.prev_gt   = (ram_rdata > r_key);
    assign o_status.lt_k      = (cnt < k_eff);
    assign o_status.scan_last = (r_lane == LW'(MAX_RESOURCES - 1));
    assign o_status.out_busy  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_vld       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (store_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (i_cmd.gr_init) begin
                r_vld   <= '0;
                r_total <= '0;
            end
            if (i_cmd.gr_free) begin
                for (int l = 0; l < MAX_RESOURCES; l++) begin
                    r_vld[l] <= r_vld[l] && (r_end[l] > ram_rdata[2*TW-1:TW]);
                end
            end
            if (i_cmd.insert) begin
                r_vld[free_lane] <= 1'b1;
                if (r_total != '1) begin
                    r_total <= r_total + CW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_fill      <= '0;
                r_ovf       <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) begin
            r_i <= CW'(1);
        end
        if (i_cmd.key_ld) begin
            r_key <= ram_rdata;
            r_j   <= r_i[AW-1:0];
        end
        if (i_cmd.shift) begin
            r_j <= r_j - AW'(1);
        end
        if (i_cmd.place || i_cmd.insert || i_cmd.replace) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.gr_init) begin
            r_i <= '0;
        end
        if (i_cmd.gr_free) begin
            r_e <= ram_rdata[TW-1:0];
        end
        if (i_cmd.insert) begin
            r_end[free_lane] <= r_e;
        end
        if (i_cmd.scan_init) begin
            r_lane <= '0;
            r_have <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            r_lane <= r_lane + LW'(1);
            if (take) begin
                r_max  <= r_end[r_lane];
                r_mi   <= r_lane;
                r_have <= 1'b1;
            end
        end
        if (i_cmd.replace && r_max > r_e) begin
            r_end[r_mi] <= r_e;
        end
        if (i_cmd.emit) begin
            r_out_count <= r_total;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_scheduled_count = r_out_count;
    assign o_overflow        = r_out_ovf;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_INTERVALS))
        else $error("fill count beyond store depth");
    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> ($countones(r_vld) <= int'(k_eff)))
        else $error("more active entries than resources");
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_fill == '0 && !r_ovf && r_out_valid))
        else $error("set state not cleared after result");
endmodule
`default_nettype wire

### rtl/k_resource_interval_scheduler.sv
// After the last interval, insertion sort reads and loads each key, shifts larger
// predecessors up and places it; the greedy pass then reads each interval, frees
// ended entries and inserts it, or on a full table runs a 16-lane max scan and
// replaces. Loading takes one interval per cycle while idle, none after the last
// interval until the result is emitted. Synchronous active-low reset clears FSM and counters.
`default_nettype none
module k_resource_interval_scheduler import krs_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [KW-1:0] i_cfg_wdata,
    krs_in_if.sink             i_in,
    krs_out_if.source          o_out
);
    logic [KW-1:0] r_resource_count;
    t_cmd          cmd;
    t_status       status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resource_count <= KW'(1);
        end else if (i_cfg_we) begin
            r_resource_count <= i_cfg_wdata;
        end
    end

    krs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .i_status   (status),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    krs_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_resource_count  (r_resource_count),
        .i_start_time      (i_in.start_time),
        .i_end_time        (i_in.end_time),
        .i_out_ready       (o_out.ready),
        .o_status          (status),
        .o_out_valid       (o_out.valid),
        .o_scheduled_count (o_out.scheduled_count),
        .o_overflow        (o_out.overflow)
    );
endmodule
`default_nettype wire

### test/k_resource_interval_scheduler_test.sv
// Testbench for k_resource_interval_scheduler: drives interval sets over the input
// channel and checks each scheduled count and overflow flag against its own greedy model.
// Depends on krs_pkg, krs_if and the scheduler RTL.
`timescale 1ns / 1ps
module k_resource_interval_scheduler_test;
    import krs_pkg::*;

    typedef struct {
        logic [CW-1:0] scheduled_count;
        logic          overflow;
    } t_tally;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [KW-1:0] i_cfg_wdata = '0;

    krs_in_if  in_ch ();
    krs_out_if out_ch ();

    k_resource_interval_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    logic [63:0] set_keys[$];
    logic        set_overflow = 1'b0;
    t_tally      tally_q[$];
    logic [KW-1:0] k_reg = 5'd1;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          cycle_no = 0;
    int          hold_until = 0;
    int          errors = 0;
    int          items_sent = 0;
    int          sets_checked = 0;
    int          quiet_cycles = 0;

    function automatic logic [CW-1:0] greedy_count(logic [63:0] keys[$], logic [KW-1:0] kr);
        logic [31:0] ends[$];
        logic [31:0] kept[$];
        logic [31:0] s;
        logic [31:0] e;
        int k;
        int mi;
        int total;
        k = (kr == 0) ? 1 : (kr > MAX_RESOURCES ? MAX_RESOURCES : int'(kr));
        keys.sort();
        total = 0;
        foreach (keys[i]) begin
            s = keys[i][63:32];
            e = keys[i][31:0];
            kept = {};
            foreach (ends[a]) if (ends[a] > s) kept.push_back(ends[a]);
            ends = kept;
            if (ends.size() < k) begin
                ends.push_back(e);
                if (total < 2047) total++;
            end else if (ends.size() > 0) begin
                mi = 0;
                for (int a = 1; a < ends.size(); a++) if (ends[a] > ends[mi]) mi = a;
                if (ends[mi] > e) ends[mi] = e;
            end
        end
        return total[CW-1:0];
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_interval(logic [31:0] s, logic [31:0] e, logic last);
        t_tally t;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.start_time <= s;
        in_ch.end_time   <= e;
        in_ch.last       <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (set_keys.size() < MAX_INTERVALS) set_keys.push_back({s, e});
        else set_overflow = 1'b1;
        if (last) begin
            t.scheduled_count = greedy_count(set_keys, k_reg);
            t.overflow        = set_overflow;
            tally_q.push_back(t);
            set_keys = {};
            set_overflow = 1'b0;
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tally_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_resources(logic [KW-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        k_reg = v;
    endtask

    task automatic random_set(int n, int span);
        logic [31:0] s;
        logic [31:0] e;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                s = $urandom;
                e = $urandom;
            end else begin
                s = $urandom_range(span);
                e = ($urandom_range(15) == 0) ? s - $urandom_range(3) : s + $urandom_range(span / 2 + 1);
            end
            send_interval(s, e, i == n - 1);
        end
    endtask

    task automatic test_directed();
        write_resources(5'd1);
        send_interval(32'd5, 32'd9, 1'b1);
        send_interval(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_interval(32'd1, 32'd2, 1'b0);
        send_interval(32'd2, 32'd3, 1'b0);
        send_interval(32'hFFFF_FFFF, 32'd0, 1'b1);
        send_interval(32'd7, 32'd7, 1'b0);
        send_interval(32'd7, 32'd7, 1'b0);
        send_interval(32'd7, 32'd8, 1'b1);
        write_resources(5'd16);
        for (int i = 0; i < 17; i++) send_interval(32'd10, 32'd100 - i, i == 16);
        write_resources(5'd0);
        send_interval(32'd3, 32'd4, 1'b0);
        send_interval(32'd3, 32'd8, 1'b1);
        write_resources(5'd31);
        random_set(20, 20);
    endtask

    task automatic test_overflow();
        write_resources(5'd3);
        for (int i = 0; i < MAX_INTERVALS + 6; i++)
            send_interval(i, i + $urandom_range(4), i == MAX_INTERVALS + 5);
        drain();
    endtask

    task automatic test_backpressure();
        write_resources(5'd2);
        idle_pct = 0;
        hold_until = cycle_no + 400;
        for (int n = 0; n < 12; n++) random_set($urandom_range(1, 6), 30);
    endtask

    task automatic test_random();
        int sent;
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 23 : 51) : 0;
            stall_pct = (phase == 2) ? 51 : ((phase == 3) ? 23 : 0);
            write_resources(KW'($urandom_range(31)));
            sent = 0;
            while (sent < 130) begin
                int n;
                n = ($urandom_range(19) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 14);
                random_set(n, $urandom_range(1, 3) * 40);
                sent += n;
                if ($urandom_range(5) == 0) write_resources(KW'($urandom_range(31)));
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    always @(posedge i_clk) begin
        if (cycle_no < hold_until) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_tally want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (tally_q.size() == 0) begin
                report("unexpected result", out_ch.scheduled_count, 0);
            end else begin
                want = tally_q.pop_front();
                sets_checked++;
                if (out_ch.scheduled_count !== want.scheduled_count)
                    report("scheduled_count", out_ch.scheduled_count, want.scheduled_count);
                if (out_ch.overflow !== want.overflow)
                    report("overflow", out_ch.overflow, want.overflow);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 200000) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("FAIL k_resource_interval_scheduler");
            $finish;
        end
    end

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.start_time = '0;
        in_ch.end_time   = '0;
        in_ch.last       = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random();
        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d intervals in %0d sets, k from 0 to 31, overflow and back-pressure",
                 items_sent, sets_checked);
        if (errors == 0 && tally_q.size() == 0) begin
            $display("PASS k_resource_interval_scheduler");
        end else begin
            $display("FAIL k_resource_interval_scheduler");
        end
        $finish;
    end
endmodule
